@@ design/mcrt_pkg.sv @@
// Shared types, constants and helper functions of the multi-channel repeat timer.
// Used by every module of the block; depends on nothing else.
package mcrt_pkg;

    localparam int NUM_SLOTS_DEF = 16;
    localparam int MAX_RESULTS   = 16;
    localparam int RES_CNT_W     = $clog2(MAX_RESULTS + 1);
    localparam int CH_W          = 4;
    localparam logic [15:0] COUNT_FOREVER = 16'hFFFF;

    typedef enum logic [2:0] {
        OP_TICK     = 3'd0,
        OP_CREATE   = 3'd1,
        OP_DESTROY  = 3'd2,
        OP_RESET    = 3'd3,
        OP_ENABLE   = 3'd4,
        OP_INTERVAL = 3'd5,
        OP_PARAMS   = 3'd6,
        OP_QUERY    = 3'd7
    } op_t;

    typedef enum logic [1:0] {
        EV_FIRED = 2'd0,
        EV_DONE  = 2'd1,
        EV_ERROR = 2'd2
    } ev_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_FLUSH,
        ST_FIND,
        ST_SINGLE
    } state_t;

    typedef struct packed {
        logic [CH_W-1:0]    channel;
        logic [31:0]        interval;
        logic signed [15:0] repeat_count;
        logic               enable;
        logic [31:0]        param_a;
        logic [31:0]        param_b;
    } in_item_t;

    typedef struct packed {
        logic        enabled;
        logic [31:0] interval;
        logic [15:0] count;
        logic [15:0] init_count;
        logic [31:0] deadline;
        logic [31:0] remaining;
        logic [31:0] arg_a;
        logic [31:0] arg_b;
    } slot_word_t;

    typedef struct packed {
        logic       en;
        slot_word_t data;
    } mem_wr_t;

    typedef struct packed {
        ev_t             kind;
        logic [CH_W-1:0] slot;
        logic [31:0]     param_a;
        logic [31:0]     param_b;
        logic            enabled;
        logic            last;
    } result_t;

    // A count is legal when it is non-negative or the unlimited mark.
    function automatic logic count_ok(logic [15:0] c);
        return (c[15] == 1'b0) || (c == COUNT_FOREVER);
    endfunction

    // Restart a slot: load interval and count, set the deadline and run it.
    function automatic slot_word_t arm_word(slot_word_t w, logic [31:0] iv,
                                            logic [15:0] c, logic [31:0] now);
        slot_word_t r;
        r            = w;
        r.interval   = iv;
        r.count      = c;
        r.init_count = c;
        r.deadline   = now + iv;
        r.enabled    = 1'b1;
        return r;
    endfunction

endpackage

@@ design/mcrt_slot_mem.sv @@
// Per-slot state memory: one write port, one read port, registered read data.
// Depends on mcrt_pkg for the slot word layout.
module mcrt_slot_mem #(
    parameter int NUM_SLOTS = mcrt_pkg::NUM_SLOTS_DEF,
    parameter int IW        = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1
) (
    input  logic                 clk,
    input  logic [IW-1:0]        rd_addr,
    output mcrt_pkg::slot_word_t rd_word,
    input  logic [IW-1:0]        wr_addr,
    input  mcrt_pkg::mem_wr_t    wr
);
    import mcrt_pkg::*;

    slot_word_t mem [NUM_SLOTS];
    slot_word_t rd_word_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr_addr] <= wr.data;
        end
        rd_word_reg <= mem[rd_addr];
    end

    assign rd_word = rd_word_reg;

endmodule

@@ design/mcrt_out_reg.sv @@
// Output register of the result stream; frees the sequencer from the receiver.
// Depends on mcrt_pkg for the result record.
module mcrt_out_reg (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              res_valid,
    input  mcrt_pkg::result_t res,
    output logic              out_free,
    output logic              out_valid,
    input  logic              out_ready,
    output mcrt_pkg::result_t out_res
);
    import mcrt_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    // The register can take a beat when it is empty or being drained.
    assign out_free = !valid_reg || out_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (out_free)
        begin
            valid_next = res_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free && res_valid)
        begin
            res_reg <= res;
        end
    end

    assign out_valid = valid_reg;
    assign out_res   = res_reg;

endmodule

@@ design/mcrt_ctrl.sv @@
// Sequencer of the timer table: time counter, slot-used bits, sweep and op handling.
// Reads and writes slot words through mcrt_slot_mem; depends on mcrt_pkg.
module mcrt_ctrl #(
    parameter int NUM_SLOTS = mcrt_pkg::NUM_SLOTS_DEF,
    parameter int IW        = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  mcrt_pkg::op_t        in_op,
    input  mcrt_pkg::in_item_t   in_item,
    input  logic                 out_free,
    output logic                 res_valid,
    output mcrt_pkg::result_t    res,
    output logic [IW-1:0]        rd_addr,
    input  mcrt_pkg::slot_word_t rd_word,
    output logic [IW-1:0]        wr_addr,
    output mcrt_pkg::mem_wr_t    wr
);
    import mcrt_pkg::*;

    localparam logic [IW-1:0] LAST_SLOT = IW'(NUM_SLOTS - 1);

    state_t                 state_reg, state_next;
    logic [31:0]            time_reg, time_next;
    logic [NUM_SLOTS-1:0]   used_reg, used_next;
    logic [IW-1:0]          cur_reg, cur_next;
    logic [RES_CNT_W-1:0]   n_reg, n_next;
    op_t                    op_reg, op_next;
    logic [CH_W-1:0]        ch_reg, ch_next;
    logic [31:0]            ival_reg, ival_next;
    logic [15:0]            cnt_reg, cnt_next;
    logic                   en_reg, en_next;
    logic [31:0]            pa_reg, pa_next;
    logic [31:0]            pb_reg, pb_next;
    logic                   pend_valid_reg, pend_valid_next;
    logic [CH_W-1:0]        pend_slot_reg, pend_slot_next;
    logic [31:0]            pend_a_reg, pend_a_next;
    logic [31:0]            pend_b_reg, pend_b_next;

    logic          cur_used;
    logic          cur_last;
    logic [IW-1:0] ch_idx;
    logic          ch_ok;
    logic          sw_due;
    logic          sw_full;
    logic          sw_fire;
    logic          sw_go;
    logic          sw_end;
    logic          find_done;

    // Decisions shared by the next-state and datapath blocks.
    always_comb
    begin
        cur_used = used_reg[cur_reg];
        cur_last = (cur_reg == LAST_SLOT);
        ch_idx   = IW'(ch_reg);
        ch_ok    = (32'(ch_reg) < 32'(NUM_SLOTS)) && used_reg[ch_idx];
        sw_due   = cur_used && (rd_word.count != 16'd0) && rd_word.enabled
                   && count_ok(rd_word.count) && (rd_word.deadline <= time_reg);
        sw_full  = (n_reg == RES_CNT_W'(MAX_RESULTS));
        sw_fire  = sw_due && !sw_full;
        sw_go    = !sw_fire || !pend_valid_reg || out_free;
        sw_end   = (sw_due && sw_full) || (sw_go && cur_last);
        find_done = !count_ok(cnt_reg) || !cur_used || cur_last;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    case (in_op)
                        OP_TICK:   state_next = ST_SWEEP;
                        OP_CREATE: state_next = ST_FIND;
                        default:   state_next = ST_SINGLE;
                    endcase
                end
            end
            ST_SWEEP:
            begin
                if (sw_end)
                begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH:
            begin
                if (!pend_valid_reg || out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_FIND:
            begin
                if (find_done && out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_SINGLE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        time_next       = time_reg;
        used_next       = used_reg;
        cur_next        = cur_reg;
        n_next          = n_reg;
        op_next         = op_reg;
        ch_next         = ch_reg;
        ival_next       = ival_reg;
        cnt_next        = cnt_reg;
        en_next         = en_reg;
        pa_next         = pa_reg;
        pb_next         = pb_reg;
        pend_valid_next = pend_valid_reg;
        pend_slot_next  = pend_slot_reg;
        pend_a_next     = pend_a_reg;
        pend_b_next     = pend_b_reg;
        res_valid       = 1'b0;
        res             = '0;
        rd_addr         = cur_reg;
        wr_addr         = cur_reg;
        wr.en           = 1'b0;
        wr.data         = rd_word;

        case (state_reg)
            ST_IDLE:
            begin
                rd_addr = (in_op == OP_TICK) ? '0 : IW'(in_item.channel);
                if (in_valid)
                begin
                    op_next         = in_op;
                    ch_next         = in_item.channel;
                    ival_next       = in_item.interval;
                    cnt_next        = in_item.repeat_count;
                    en_next         = in_item.enable;
                    pa_next         = in_item.param_a;
                    pb_next         = in_item.param_b;
                    cur_next        = '0;
                    n_next          = '0;
                    pend_valid_next = 1'b0;
                    if (in_op == OP_TICK)
                    begin
                        time_next = time_reg + 32'd1;
                    end
                end
            end
            ST_SWEEP:
            begin
                if (sw_go && !(sw_due && sw_full))
                begin
                    cur_next = IW'(cur_reg + 1'b1);
                    rd_addr  = IW'(cur_reg + 1'b1);
                    if (sw_fire)
                    begin
                        // Hold the firing back one step so the final one can carry last.
                        if (pend_valid_reg)
                        begin
                            res_valid     = 1'b1;
                            res.kind      = EV_FIRED;
                            res.slot      = pend_slot_reg;
                            res.param_a   = pend_a_reg;
                            res.param_b   = pend_b_reg;
                        end
                        pend_valid_next = 1'b1;
                        pend_slot_next  = CH_W'(cur_reg);
                        pend_a_next     = rd_word.arg_a;
                        pend_b_next     = rd_word.arg_b;
                        n_next          = n_reg + 1'b1;
                        wr.en           = 1'b1;
                        if (rd_word.count == COUNT_FOREVER)
                        begin
                            wr.data.deadline = rd_word.deadline + rd_word.interval;
                        end
                        else
                        begin
                            wr.data.count = rd_word.count - 16'd1;
                            if (rd_word.count == 16'd1)
                            begin
                                used_next[cur_reg] = 1'b0;
                            end
                            else
                            begin
                                wr.data.deadline = rd_word.deadline + rd_word.interval;
                            end
                        end
                    end
                    else if (cur_used && (rd_word.count == 16'd0))
                    begin
                        used_next[cur_reg] = 1'b0;
                    end
                end
            end
            ST_FLUSH:
            begin
                if (pend_valid_reg && out_free)
                begin
                    res_valid       = 1'b1;
                    res.kind        = EV_FIRED;
                    res.slot        = pend_slot_reg;
                    res.param_a     = pend_a_reg;
                    res.param_b     = pend_b_reg;
                    res.last        = 1'b1;
                    pend_valid_next = 1'b0;
                end
            end
            ST_FIND:
            begin
                if (!count_ok(cnt_reg) || (cur_used && cur_last))
                begin
                    if (out_free)
                    begin
                        res_valid = 1'b1;
                        res.kind  = EV_ERROR;
                        res.last  = 1'b1;
                    end
                end
                else if (!cur_used)
                begin
                    if (out_free)
                    begin
                        res_valid          = 1'b1;
                        res.kind           = EV_DONE;
                        res.slot           = CH_W'(cur_reg);
                        res.last           = 1'b1;
                        used_next[cur_reg] = 1'b1;
                        wr.en              = 1'b1;
                        wr.data            = arm_word(rd_word, ival_reg, cnt_reg, time_reg);
                        wr.data.remaining  = '0;
                        wr.data.arg_a      = pa_reg;
                        wr.data.arg_b      = pb_reg;
                    end
                end
                else
                begin
                    cur_next = IW'(cur_reg + 1'b1);
                end
            end
            ST_SINGLE:
            begin
                rd_addr = ch_idx;
                wr_addr = ch_idx;
                if (out_free)
                begin
                    res_valid = 1'b1;
                    res.kind  = EV_DONE;
                    res.slot  = ch_reg;
                    res.last  = 1'b1;
                    if (!ch_ok)
                    begin
                        res.kind = EV_ERROR;
                    end
                    else
                    begin
                        case (op_reg)
                            OP_DESTROY:
                            begin
                                used_next[ch_idx] = 1'b0;
                            end
                            OP_RESET:
                            begin
                                wr.en   = 1'b1;
                                wr.data = arm_word(rd_word, rd_word.interval,
                                                   rd_word.init_count, time_reg);
                            end
                            OP_ENABLE:
                            begin
                                // Pause keeps the time left; resume rebuilds the deadline.
                                if (rd_word.enabled && !en_reg)
                                begin
                                    wr.en             = 1'b1;
                                    wr.data.remaining = rd_word.deadline - time_reg;
                                    wr.data.enabled   = 1'b0;
                                end
                                else if (!rd_word.enabled && en_reg)
                                begin
                                    wr.en            = 1'b1;
                                    wr.data.deadline = rd_word.remaining + time_reg;
                                    wr.data.enabled  = 1'b1;
                                end
                            end
                            OP_INTERVAL:
                            begin
                                if (!count_ok(cnt_reg))
                                begin
                                    res.kind = EV_ERROR;
                                end
                                else
                                begin
                                    wr.en   = 1'b1;
                                    wr.data = arm_word(rd_word, ival_reg, cnt_reg, time_reg);
                                end
                            end
                            OP_PARAMS:
                            begin
                                wr.en         = 1'b1;
                                wr.data.arg_a = pa_reg;
                                wr.data.arg_b = pb_reg;
                            end
                            OP_QUERY:
                            begin
                                res.enabled = rd_word.enabled;
                            end
                            default:
                            begin
                                res.kind = EV_DONE;
                            end
                        endcase
                    end
                end
            end
            default:
            begin
                res_valid = 1'b0;
            end
        endcase
    end

    assign in_ready = (state_reg == ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            time_reg       <= '0;
            used_reg       <= '0;
            cur_reg        <= '0;
            n_reg          <= '0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            time_reg       <= time_next;
            used_reg       <= used_next;
            cur_reg        <= cur_next;
            n_reg          <= n_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        ch_reg        <= ch_next;
        ival_reg      <= ival_next;
        cnt_reg       <= cnt_next;
        en_reg        <= en_next;
        pa_reg        <= pa_next;
        pb_reg        <= pb_next;
        pend_slot_reg <= pend_slot_next;
        pend_a_reg    <= pend_a_next;
        pend_b_reg    <= pend_b_next;
    end

endmodule

@@ design/multi_channel_repeat_timer.sv @@
// Top level of the multi-channel repeat timer: unpacks the command stream,
// joins sequencer, slot memory and output register. Depends on mcrt_pkg.
//
// Usage:
//   s_axis carries commands: tuser is the op (tick, create, destroy, reset,
//   set enable, set interval, set params, query), tdata the operands.
//   m_axis carries results: tuser is the event kind (fired, done, error),
//   tdata the slot, stored callback parameters and enable status; tlast
//   marks the final beat caused by one command.
// Operation:
//   One command is worked at a time. A tick is accepted, then sweeps the
//   slots in order out of the slot memory (its single read port sets the
//   pace) and finally releases the held-back final firing. Create scans
//   the used bits for a free slot; every other op is accepted and then
//   answered with one beat. At most 16 firings come out per tick;
//   slots not reached stay pending for the next tick.
// Reset:
//   rst_n clears the time counter, all used bits and the handshake state;
//   no clearing pass over the memory is needed.
// Stalls:
//   A result waits in the output register while m_axis_tready is low; the
//   sweep holds on the next firing until the register drains, and a new
//   command can be taken meanwhile once the sequencer is idle.
module multi_channel_repeat_timer #(
    parameter int NUM_SLOTS = mcrt_pkg::NUM_SLOTS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // tdata from bit 0: channel[3:0], interval[31:0], repeat_count[15:0],
    // enable, param_a[31:0], param_b[31:0], 3 zero bits
    input  logic [119:0] s_axis_tdata,
    // tuser: op[2:0]
    input  logic [2:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // tdata from bit 0: slot[3:0], out_param_a[31:0], out_param_b[31:0],
    // enabled, 3 zero bits
    output logic [71:0]  m_axis_tdata,
    // tuser: event_kind[1:0]
    output logic [1:0]   m_axis_tuser,
    output logic         m_axis_tlast
);
    import mcrt_pkg::*;

    localparam int IW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

    in_item_t      in_item;
    op_t           in_op;
    logic          out_free;
    logic          res_valid;
    result_t       res;
    result_t       out_res;
    logic [IW-1:0] rd_addr;
    logic [IW-1:0] wr_addr;
    slot_word_t    rd_word;
    mem_wr_t       wr;

    // Unpack the command beat.
    always_comb
    begin
        in_op                = op_t'(s_axis_tuser);
        in_item.channel      = s_axis_tdata[3:0];
        in_item.interval     = s_axis_tdata[35:4];
        in_item.repeat_count = s_axis_tdata[51:36];
        in_item.enable       = s_axis_tdata[52];
        in_item.param_a      = s_axis_tdata[84:53];
        in_item.param_b      = s_axis_tdata[116:85];
    end

    mcrt_ctrl #(
        .NUM_SLOTS (NUM_SLOTS),
        .IW        (IW)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_op     (in_op),
        .in_item   (in_item),
        .out_free  (out_free),
        .res_valid (res_valid),
        .res       (res),
        .rd_addr   (rd_addr),
        .rd_word   (rd_word),
        .wr_addr   (wr_addr),
        .wr        (wr)
    );

    mcrt_slot_mem #(
        .NUM_SLOTS (NUM_SLOTS),
        .IW        (IW)
    ) u_mem (
        .clk     (clk),
        .rd_addr (rd_addr),
        .rd_word (rd_word),
        .wr_addr (wr_addr),
        .wr      (wr)
    );

    mcrt_out_reg u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res       (res),
        .out_free  (out_free),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_res   (out_res)
    );

    // Pack the result beat.
    assign m_axis_tdata = {3'b000, out_res.enabled, out_res.param_b,
                           out_res.param_a, out_res.slot};
    assign m_axis_tuser = out_res.kind;
    assign m_axis_tlast = out_res.last;

endmodule

@@ tb/multi_channel_repeat_timer_test.sv @@
// Self-checking testbench of the multi-channel repeat timer: drives command beats, predicts
// every fired, done and error beat from its own slot table and checks them in order.
// Depends on mcrt_pkg and multi_channel_repeat_timer.
`timescale 1ns / 1ps

module multi_channel_repeat_timer_test;

    import mcrt_pkg::*;

    localparam int NSLOT      = NUM_SLOTS_DEF;
    localparam int RAND_ITEMS = 400;
    localparam int IDLE_LIMIT = 4000;
    localparam int DRAIN_WAIT = 40;

    // One pending command: the op travels in tuser, the rest in tdata.
    typedef struct packed {
        op_t      op;
        in_item_t body;
    } timer_cmd_t;

    logic         clk = 1'b0;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [119:0] s_axis_tdata;
    logic [2:0]   s_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [71:0]  m_axis_tdata;
    logic [1:0]   m_axis_tuser;
    logic         m_axis_tlast;

    multi_channel_repeat_timer dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Slot table as the testbench sees it
    // ------------------------------------------------------------------
    logic [31:0] tm_now;
    logic        tm_used      [NSLOT];
    logic        tm_enabled   [NSLOT];
    logic [31:0] tm_interval  [NSLOT];
    logic [15:0] tm_count     [NSLOT];
    logic [15:0] tm_init_count[NSLOT];
    logic [31:0] tm_deadline  [NSLOT];
    logic [31:0] tm_remaining [NSLOT];
    logic [31:0] tm_arg_a     [NSLOT];
    logic [31:0] tm_arg_b     [NSLOT];

    timer_cmd_t cmd_queue[$];        // commands waiting for the driver
    result_t    expected_events[$];  // result beats still owed by the block
    timer_cmd_t cmd_on_bus;
    result_t    got_event;
    result_t    want_event;

    bit in_taken;
    bit calm;
    int send_gap;
    int stall_left;
    int idle_cycles;
    int mismatch_count;
    int random_items;
    int cmds_accepted;
    int ticks_seen;
    int results_seen;
    int fired_seen;
    int error_seen;
    int table_full_seen;
    int pause_seen;
    int biggest_sweep;

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        $display("[%0t] mismatch: %s", $time, msg);
    endtask

    function automatic bit count_legal(logic [15:0] c);
        return (c[15] == 1'b0) || (c == COUNT_FOREVER);
    endfunction

    task automatic owe_event(ev_t kind, logic [3:0] s, logic [31:0] pa, logic [31:0] pb,
                             logic en);
        result_t r;
        r.kind    = kind;
        r.slot    = s;
        r.param_a = pa;
        r.param_b = pb;
        r.enabled = en;
        r.last    = 1'b1;
        expected_events.push_back(r);
    endtask

    task automatic arm_slot(int s, logic [31:0] iv, logic [15:0] c);
        tm_interval[s]   = iv;
        tm_count[s]      = c;
        tm_init_count[s] = c;
        tm_deadline[s]   = tm_now + iv;
        tm_enabled[s]    = 1'b1;
    endtask

    // Advance time and sweep the table. Hold back each firing until the next
    // one is known so that only the final beat carries last.
    task automatic sweep_tick();
        result_t held;
        bit      have_held;
        int      n;
        ticks_seen++;
        have_held = 1'b0;
        n         = 0;
        tm_now    = tm_now + 32'd1;
        for (int s = 0; s < NSLOT; s++) begin
            if (!tm_used[s])
                continue;
            if (tm_count[s] == 16'd0) begin
                tm_used[s] = 1'b0;
                continue;
            end
            if (!tm_enabled[s] || !count_legal(tm_count[s]))
                continue;
            if (tm_deadline[s] > tm_now)
                continue;
            if (n >= MAX_RESULTS)
                break;
            if (have_held)
                expected_events.push_back(held);
            held.kind    = EV_FIRED;
            held.slot    = s[3:0];
            held.param_a = tm_arg_a[s];
            held.param_b = tm_arg_b[s];
            held.enabled = 1'b0;
            held.last    = 1'b0;
            have_held    = 1'b1;
            n++;
            if (tm_count[s] == COUNT_FOREVER) begin
                tm_deadline[s] = tm_deadline[s] + tm_interval[s];
            end else begin
                tm_count[s] = tm_count[s] - 16'd1;
                if (tm_count[s] == 16'd0)
                    tm_used[s] = 1'b0;
                else
                    tm_deadline[s] = tm_deadline[s] + tm_interval[s];
            end
        end
        if (have_held) begin
            held.last = 1'b1;
            expected_events.push_back(held);
        end
        if (n > biggest_sweep)
            biggest_sweep = n;
    endtask

    // Apply one accepted command to the slot table and queue the beats it owes.
    task automatic predict_command(timer_cmd_t c);
        int ch;
        int free_slot;
        ch = int'(c.body.channel);
        cmds_accepted++;
        if (c.op == OP_TICK) begin
            sweep_tick();
        end else if (c.op == OP_CREATE) begin
            free_slot = -1;
            for (int s = 0; s < NSLOT; s++)
                if (free_slot < 0 && !tm_used[s])
                    free_slot = s;
            if (!count_legal(c.body.repeat_count)) begin
                owe_event(EV_ERROR, 4'd0, 32'd0, 32'd0, 1'b0);
            end else if (free_slot < 0) begin
                table_full_seen++;
                owe_event(EV_ERROR, 4'd0, 32'd0, 32'd0, 1'b0);
            end else begin
                tm_used[free_slot] = 1'b1;
                arm_slot(free_slot, c.body.interval, c.body.repeat_count);
                tm_remaining[free_slot] = 32'd0;
                tm_arg_a[free_slot]     = c.body.param_a;
                tm_arg_b[free_slot]     = c.body.param_b;
                owe_event(EV_DONE, free_slot[3:0], 32'd0, 32'd0, 1'b0);
            end
        end else if (!tm_used[ch]) begin
            owe_event(EV_ERROR, c.body.channel, 32'd0, 32'd0, 1'b0);
        end else if (c.op == OP_INTERVAL && !count_legal(c.body.repeat_count)) begin
            owe_event(EV_ERROR, c.body.channel, 32'd0, 32'd0, 1'b0);
        end else if (c.op == OP_QUERY) begin
            owe_event(EV_DONE, c.body.channel, 32'd0, 32'd0, tm_enabled[ch]);
        end else begin
            case (c.op)
                OP_DESTROY: tm_used[ch] = 1'b0;
                OP_RESET:   arm_slot(ch, tm_interval[ch], tm_init_count[ch]);
                OP_ENABLE: begin
                    // Pause keeps the time left; resume rebuilds the deadline from it.
                    if (tm_enabled[ch] && !c.body.enable) begin
                        tm_remaining[ch] = tm_deadline[ch] - tm_now;
                        tm_enabled[ch]   = 1'b0;
                        pause_seen++;
                    end else if (!tm_enabled[ch] && c.body.enable) begin
                        tm_deadline[ch] = tm_remaining[ch] + tm_now;
                        tm_enabled[ch]  = 1'b1;
                    end
                end
                OP_INTERVAL: arm_slot(ch, c.body.interval, c.body.repeat_count);
                OP_PARAMS: begin
                    tm_arg_a[ch] = c.body.param_a;
                    tm_arg_b[ch] = c.body.param_b;
                end
                default: ;
            endcase
            owe_event(EV_DONE, c.body.channel, 32'd0, 32'd0, 1'b0);
        end
    endtask

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic push_cmd(op_t op, logic [3:0] ch, logic [31:0] iv, logic [15:0] rc,
                            logic en, logic [31:0] pa, logic [31:0] pb);
        timer_cmd_t c;
        c.op                = op;
        c.body.channel      = ch;
        c.body.interval     = iv;
        c.body.repeat_count = rc;
        c.body.enable       = en;
        c.body.param_a      = pa;
        c.body.param_b      = pb;
        cmd_queue.push_back(c);
        random_items++;
    endtask

    // Mostly short gaps, now and then a long one; none at all in calm stretches.
    function automatic int idle_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Small intervals keep slots firing; a few span the whole 32-bit range.
    function automatic logic [31:0] rand_interval();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return $urandom_range(0, 4);
        if (r < 75)
            return $urandom_range(5, 30);
        if (r < 90)
            return $urandom;
        return 32'hFFFF_FFFF - $urandom_range(0, 2);
    endfunction

    function automatic logic [15:0] rand_count();
        int r;
        r = $urandom_range(0, 99);
        if (r < 35)
            return COUNT_FOREVER;
        if (r < 75)
            return 16'($urandom_range(1, 10));
        if (r < 83)
            return 16'd0;
        if (r < 90)
            return 16'($urandom_range(11, 32767));
        return 16'($urandom_range(16'h8000, 16'hFFFE));
    endfunction

    // Aim mostly at slots in use so that commands get past the used check.
    function automatic logic [3:0] pick_channel();
        int live[$];
        for (int s = 0; s < NSLOT; s++)
            if (tm_used[s])
                live.push_back(s);
        if (live.size() != 0 && $urandom_range(0, 99) < 80)
            return 4'(live[$urandom_range(0, live.size() - 1)]);
        return 4'($urandom_range(0, NSLOT - 1));
    endfunction

    task automatic push_random(op_t op, logic [3:0] ch);
        push_cmd(op, ch, rand_interval(), rand_count(), 1'($urandom_range(0, 1)), $urandom,
                 $urandom);
    endtask

    // ------------------------------------------------------------------
    // Driver: present the next command beat at the falling edge
    // ------------------------------------------------------------------
    always @(negedge clk) begin
        if (rst_n) begin
            if (in_taken || !s_axis_tvalid) begin
                in_taken = 1'b0;
                if (send_gap > 0) begin
                    send_gap--;
                    s_axis_tvalid <= 1'b0;
                end else if (cmd_queue.size() != 0) begin
                    cmd_on_bus = cmd_queue.pop_front();
                    s_axis_tuser  <= cmd_on_bus.op;
                    s_axis_tdata  <= {3'b000, cmd_on_bus.body.param_b,
                                      cmd_on_bus.body.param_a, cmd_on_bus.body.enable,
                                      cmd_on_bus.body.repeat_count, cmd_on_bus.body.interval,
                                      cmd_on_bus.body.channel};
                    s_axis_tvalid <= 1'b1;
                    send_gap = idle_gap();
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
            // Receiver side: drop ready for a random stretch, then raise it again.
            if (stall_left > 0) begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
                stall_left = idle_gap();
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: take beats at the rising edge, predict and check
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        if (rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                predict_command(cmd_on_bus);
                in_taken = 1'b1;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                results_seen++;
                got_event.kind    = ev_t'(m_axis_tuser);
                got_event.slot    = m_axis_tdata[3:0];
                got_event.param_a = m_axis_tdata[35:4];
                got_event.param_b = m_axis_tdata[67:36];
                got_event.enabled = m_axis_tdata[68];
                got_event.last    = m_axis_tlast;
                if (got_event.kind == EV_FIRED)
                    fired_seen++;
                if (got_event.kind == EV_ERROR)
                    error_seen++;
                if (expected_events.size() == 0) begin
                    report_mismatch($sformatf("beat %0d unexpected: kind %0d slot %0d",
                                              results_seen, got_event.kind, got_event.slot));
                end else begin
                    want_event = expected_events.pop_front();
                    if (got_event.kind != want_event.kind)
                        report_mismatch($sformatf("beat %0d kind %0d, want %0d", results_seen,
                                                  got_event.kind, want_event.kind));
                    if (got_event.slot != want_event.slot)
                        report_mismatch($sformatf("beat %0d slot %0d, want %0d", results_seen,
                                                  got_event.slot, want_event.slot));
                    if (got_event.param_a != want_event.param_a)
                        report_mismatch($sformatf("beat %0d param_a %h, want %h", results_seen,
                                                  got_event.param_a, want_event.param_a));
                    if (got_event.param_b != want_event.param_b)
                        report_mismatch($sformatf("beat %0d param_b %h, want %h", results_seen,
                                                  got_event.param_b, want_event.param_b));
                    if (got_event.enabled != want_event.enabled)
                        report_mismatch($sformatf("beat %0d enabled %0d, want %0d",
                                                  results_seen, got_event.enabled,
                                                  want_event.enabled));
                    if (got_event.last != want_event.last)
                        report_mismatch($sformatf("beat %0d last %0d, want %0d", results_seen,
                                                  got_event.last, want_event.last));
                end
            end
        end
    end

    // Watchdog: end the run if no beat moves on either side for too long.
    always @(posedge clk) begin
        if (rst_n) begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("[%0t] timeout: no beat for %0d cycles", $time, IDLE_LIMIT);
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Reset, stimulus and end of run
    // ------------------------------------------------------------------
    initial begin
        logic [3:0] ch;
        int         r;
        int         k;
        rst_n          = 1'b0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        s_axis_tuser   = OP_TICK;
        m_axis_tready  = 1'b0;
        in_taken       = 1'b0;
        calm           = 1'b0;
        send_gap       = 0;
        stall_left     = 0;
        idle_cycles    = 0;
        mismatch_count = 0;
        random_items   = 0;
        tm_now         = 32'd0;
        for (int s = 0; s < NSLOT; s++)
            tm_used[s] = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed part: errors on empty slots, field extremes, zero and bad
        // counts, pause/resume with a repeated enable, retime, restart, wrap.
        push_cmd(OP_QUERY,    4'd5,  32'd0, 16'd0, 1'b0, 32'd0, 32'd0);
        push_cmd(OP_DESTROY,  4'd15, 32'hFFFF_FFFF, 16'hFFFF, 1'b1, 32'hFFFF_FFFF,
                 32'hFFFF_FFFF);
        push_cmd(OP_CREATE,   4'd0,  32'd1, 16'd2, 1'b0, 32'hFFFF_FFFF, 32'd0);
        push_cmd(OP_CREATE,   4'd0,  32'd0, COUNT_FOREVER, 1'b1, 32'd0, 32'hFFFF_FFFF);
        push_cmd(OP_CREATE,   4'd0,  32'd3, 16'd0, 1'b0, 32'h1234_5678, 32'h9ABC_DEF0);
        push_cmd(OP_CREATE,   4'd0,  32'd2, 16'h8000, 1'b0, 32'd1, 32'd2);
        push_cmd(OP_TICK,     4'd0,  32'd0, 16'd0, 1'b0, 32'd0, 32'd0);
        push_cmd(OP_CREATE,   4'd0,  32'hFFFF_FFFF, 16'd3, 1'b0, 32'hA5A5_A5A5,
                 32'h5A5A_5A5A);
        push_cmd(OP_TICK,     4'd0,  32'd0, 16'd0, 1'b0, 32'd0, 32'd0);
        push_cmd(OP_ENABLE,   4'd1,  32'd0, 16'd0, 1'b0, 32'd0, 32'd0);
        push_cmd(OP_ENABLE,   4'd1,  32'd0, 16'd0, 1'b0, 32'd0, 32'd0);
        push_cmd(OP_QUERY,    4'd1,  32'd0, 16'd0, 1'b0, 32'd0, 32'd0);
        push_cmd(OP_TICK,     4'd0,  32'd0, 16'd0, 1'b0, 32'd0, 32'd0);
        push_cmd(OP_ENABLE,   4'd1,  32'd0, 16'd0, 1'b1, 32'd0, 32'd0);
        push_cmd(OP_INTERVAL, 4'd0,  32'd4, 16'hFFFE, 1'b0, 32'd0, 32'd0);
        push_cmd(OP_INTERVAL, 4'd0,  32'd0, 16'd2, 1'b0, 32'd0, 32'd0);
        push_cmd(OP_PARAMS,   4'd1,  32'd0, 16'd0, 1'b0, 32'hDEAD_BEEF, 32'hCAFE_F00D);
        push_cmd(OP_TICK,     4'd0,  32'd0, 16'd0, 1'b0, 32'd0, 32'd0);
        push_cmd(OP_RESET,    4'd0,  32'd0, 16'd0, 1'b0, 32'd0, 32'd0);
        push_cmd(OP_DESTROY,  4'd1,  32'd0, 16'd0, 1'b0, 32'd0, 32'd0);
        push_cmd(OP_QUERY,    4'd1,  32'd0, 16'd0, 1'b0, 32'd0, 32'd0);
        push_cmd(OP_TICK,     4'd0,  32'd0, 16'd0, 1'b0, 32'd0, 32'd0);
        push_cmd(OP_CREATE,   4'd0,  32'd2, 16'h7FFF, 1'b1, 32'h0F0F_0F0F, 32'hF0F0_F0F0);
        push_cmd(OP_INTERVAL, 4'd1,  32'd5, 16'd0, 1'b0, 32'd0, 32'd0);
        push_cmd(OP_TICK,     4'd0,  32'd0, 16'd0, 1'b0, 32'd0, 32'd0);
        random_items = 0;

        // Random part: fed a couple of commands ahead so channels can follow
        // the live table.
        while (random_items < RAND_ITEMS) begin
            while (cmd_queue.size() >= 2)
                @(negedge clk);
            if ((random_items % 50) == 0)
                calm = ($urandom_range(0, 3) == 0);
            r = $urandom_range(0, 99);
            if (r < 5) begin
                // Fill the table with fast timers, then sweep it.
                k = $urandom_range(4, NSLOT + 1);
                repeat (k)
                    push_cmd(OP_CREATE, 4'($urandom), $urandom_range(0, 2),
                             ($urandom_range(0, 1) ? COUNT_FOREVER
                                                   : 16'($urandom_range(1, 5))),
                             1'($urandom_range(0, 1)), $urandom, $urandom);
                repeat (2)
                    push_random(OP_TICK, 4'($urandom));
            end else if (r < 9) begin
                // Pause a live slot, let time pass, look at it, resume.
                ch = pick_channel();
                push_cmd(OP_ENABLE, ch, $urandom, 16'($urandom), 1'b0, $urandom, $urandom);
                repeat ($urandom_range(1, 4))
                    push_random(OP_TICK, 4'($urandom));
                push_random(OP_QUERY, ch);
                push_cmd(OP_ENABLE, ch, $urandom, 16'($urandom), 1'b1, $urandom, $urandom);
                push_random(OP_TICK, 4'($urandom));
            end else if (r < 12) begin
                // Drain part of the table.
                repeat ($urandom_range(3, 8))
                    push_random(OP_DESTROY, pick_channel());
            end else if (r < 45) begin
                push_random(OP_TICK, 4'($urandom));
            end else if (r < 62) begin
                push_random(OP_CREATE, 4'($urandom));
            end else if (r < 67) begin
                push_random(OP_DESTROY, pick_channel());
            end else if (r < 73) begin
                push_random(OP_RESET, pick_channel());
            end else if (r < 81) begin
                push_random(OP_ENABLE, pick_channel());
            end else if (r < 88) begin
                push_random(OP_INTERVAL, pick_channel());
            end else if (r < 94) begin
                push_random(OP_PARAMS, pick_channel());
            end else begin
                push_random(OP_QUERY, pick_channel());
            end
        end

        // Wait for every command to go in and every owed beat to come out, then
        // give a silent tick time to finish its sweep.
        while (cmd_queue.size() != 0 || s_axis_tvalid)
            @(negedge clk);
        while (expected_events.size() != 0)
            @(negedge clk);
        repeat (DRAIN_WAIT) @(negedge clk);
        if (expected_events.size() != 0)
            report_mismatch($sformatf("%0d result beats never arrived",
                                      expected_events.size()));

        $display("Covered %0d commands (%0d ticks, %0d pauses, %0d table-full creates).",
                 cmds_accepted, ticks_seen, pause_seen, table_full_seen);
        $display("Checked %0d result beats: %0d firings, %0d errors, up to %0d per tick.",
                 results_seen, fired_seen, error_seen, biggest_sweep);
        if (mismatch_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

@@ sim.f @@
design/mcrt_pkg.sv
design/mcrt_slot_mem.sv
design/mcrt_out_reg.sv
design/mcrt_ctrl.sv
design/multi_channel_repeat_timer.sv
tb/multi_channel_repeat_timer_test.sv
